/* sv/wpi_pkg.sv */
// ----------------------------------------------------------------------------
// wpi_pkg : shared types, constants and knot tables
// Knot ROMs for density, viscosity and heat capacity of water from 0 to
// 100 C in 10 C steps, the segment divider constants and pipeline types.
// ----------------------------------------------------------------------------
package wpi_pkg;

  // knot table geometry
  localparam int KNOT_COUNT = 11;
  localparam int KNOT_STEP  = 1000;
  localparam int SEG_W      = $clog2(KNOT_COUNT);
  localparam int TC_TOP     = (KNOT_COUNT - 1) * KNOT_STEP;
  localparam int MID_W      = $clog2(TC_TOP);
  localparam int FRAC_W     = $clog2(KNOT_STEP);

  // Kelvin to Celsius offset, in hundredths
  localparam int OFFSET_CK = 27315;
  localparam int TK_W      = 16;
  localparam int TC_W      = TK_W + 1;

  // tc / 1000 as (tc * SEG_RECIP) >> SEG_SHIFT, exact for tc below TC_TOP
  localparam int SEG_SHIFT = 23;
  localparam int SEG_RECIP = 8389;
  localparam int RECIP_W   = 14;
  localparam int SEGP_W    = MID_W + RECIP_W;

  // rounding divide by 1000 on a biased numerator
  localparam int DIV_BIAS  = 5000;
  localparam int NUM_W     = 24;
  localparam int DIV_SHIFT = 34;
  localparam int DIV_RECIP = 17179870;
  localparam int DRECIP_W  = 25;
  localparam int DIVP_W    = NUM_W + DRECIP_W;
  localparam int QUO_W     = DIVP_W - DIV_SHIFT;

  // value and slope widths shared by all three lanes
  localparam int VAL_W   = 19;
  localparam int DELTA_W = 15;
  localparam int PROD_W  = 25;

  // result field widths
  localparam int DENS_W = 17;
  localparam int VISC_W = 15;
  localparam int HEAT_W = 19;

  // lane property codes
  localparam logic [1:0] PROP_DENSITY   = 2'd0;
  localparam logic [1:0] PROP_VISCOSITY = 2'd1;
  localparam logic [1:0] PROP_HEAT      = 2'd2;

  // pipeline stage count and per-stage advance enables
  localparam int PIPE_DEPTH = 6;
  typedef logic [PIPE_DEPTH-1:0] pipe_en_t;

  typedef logic [VAL_W-1:0] knot_t;

  localparam knot_t DENSITY_ROM [KNOT_COUNT] = '{
    19'd99984, 19'd99970, 19'd99821, 19'd99565, 19'd99222, 19'd98804,
    19'd98320, 19'd97776, 19'd97179, 19'd96531, 19'd95835
  };
  localparam knot_t VISCOSITY_ROM [KNOT_COUNT] = '{
    19'd17914, 19'd13060, 19'd10016, 19'd7972, 19'd6527, 19'd5465,
    19'd4660, 19'd4035, 19'd3540, 19'd3142, 19'd2816
  };
  localparam knot_t HEAT_ROM [KNOT_COUNT] = '{
    19'd421900, 19'd419500, 19'd418400, 19'd418000, 19'd417900, 19'd418100,
    19'd418500, 19'd419000, 19'd419600, 19'd420500, 19'd421600
  };

  // knot value of one property; out-of-range indexes read zero
  function automatic knot_t knot_value(input logic [1:0] prop,
                                       input logic [SEG_W-1:0] idx);
    knot_t v;
    v = '0;
    if (32'(idx) < KNOT_COUNT) begin
      case (prop)
        PROP_DENSITY:   v = DENSITY_ROM[idx];
        PROP_VISCOSITY: v = VISCOSITY_ROM[idx];
        PROP_HEAT:      v = HEAT_ROM[idx];
        default:        v = '0;
      endcase
    end
    return v;
  endfunction

  // slope to the next knot; zero on the last knot
  function automatic logic signed [DELTA_W-1:0] knot_delta(input logic [1:0] prop,
                                                           input logic [SEG_W-1:0] idx);
    logic signed [VAL_W:0] d;
    d = '0;
    if (32'(idx) < KNOT_COUNT - 1) begin
      d = $signed({1'b0, knot_value(prop, idx + SEG_W'(1))})
        - $signed({1'b0, knot_value(prop, idx)});
    end
    return d[DELTA_W-1:0];
  endfunction

endpackage

/* sv/water_property_interpolator_core.sv */
// ----------------------------------------------------------------------------
// water_property_interpolator_core : water properties from temperature
// Clamped linear interpolation of density, viscosity and heat capacity over
// an 11-knot table from 0 to 100 C.
//
//   channel      | handshake                         | word
//   -------------+-----------------------------------+----------------------------
//   temperature  | temperature_valid / _ready        | temperature_centikelvin
//   result       | result_valid / result_ready       | density_centi,
//                |                                   | viscosity_tenth_micro,
//                |                                   | heat_capacity_centi, clamped
//
// Six register stages; a word enters every cycle unless the output stalls.
// Each stage holds a valid bit and loads when empty or when the next stage
// loads, so bubbles close up and a stall at the output backs up one stage
// at a time. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module water_property_interpolator_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         temperature_valid,
  output logic                         temperature_ready,
  input  logic [wpi_pkg::TK_W-1:0]     temperature_centikelvin,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [wpi_pkg::DENS_W-1:0]   density_centi,
  output logic [wpi_pkg::VISC_W-1:0]   viscosity_tenth_micro,
  output logic [wpi_pkg::HEAT_W-1:0]   heat_capacity_centi,
  output logic                         clamped
);

  wpi_pkg::pipe_en_t                 en;
  logic [wpi_pkg::PIPE_DEPTH-1:0]    stage_valid;
  logic [wpi_pkg::SEG_W-1:0]         seg_idx;
  logic [wpi_pkg::FRAC_W-1:0]        frac;
  logic                              seg_clamped;
  logic [2:0]                        clamped_dly;
  logic [wpi_pkg::VAL_W-1:0]         dens_val;
  logic [wpi_pkg::VAL_W-1:0]         visc_val;
  logic [wpi_pkg::VAL_W-1:0]         heat_val;

  // stage enables: load when empty or when downstream takes the word
  always_comb begin
    en[wpi_pkg::PIPE_DEPTH-1] = !stage_valid[wpi_pkg::PIPE_DEPTH-1] || result_ready;
    for (int i = wpi_pkg::PIPE_DEPTH - 2; i >= 0; i--) begin
      en[i] = !stage_valid[i] || en[i+1];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (en[0]) begin
        stage_valid[0] <= temperature_valid;
      end
      for (int i = 1; i < wpi_pkg::PIPE_DEPTH; i++) begin
        if (en[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  assign temperature_ready = en[0];
  assign result_valid      = stage_valid[wpi_pkg::PIPE_DEPTH-1];

  wpi_seg u_seg (
    .clk                     (clk),
    .en                      (en),
    .temperature_centikelvin (temperature_centikelvin),
    .seg_idx                 (seg_idx),
    .frac                    (frac),
    .clamped                 (seg_clamped)
  );

  wpi_lerp u_lerp_density (
    .clk     (clk),
    .en      (en),
    .prop    (wpi_pkg::PROP_DENSITY),
    .seg_idx (seg_idx),
    .frac    (frac),
    .value   (dens_val)
  );

  wpi_lerp u_lerp_viscosity (
    .clk     (clk),
    .en      (en),
    .prop    (wpi_pkg::PROP_VISCOSITY),
    .seg_idx (seg_idx),
    .frac    (frac),
    .value   (visc_val)
  );

  wpi_lerp u_lerp_heat (
    .clk     (clk),
    .en      (en),
    .prop    (wpi_pkg::PROP_HEAT),
    .seg_idx (seg_idx),
    .frac    (frac),
    .value   (heat_val)
  );

  // clamp flag delayed alongside the lanes
  always_ff @(posedge clk) begin
    if (en[3]) clamped_dly[0] <= seg_clamped;
    if (en[4]) clamped_dly[1] <= clamped_dly[0];
    if (en[5]) clamped_dly[2] <= clamped_dly[1];
  end

  assign density_centi         = dens_val[wpi_pkg::DENS_W-1:0];
  assign viscosity_tenth_micro = visc_val[wpi_pkg::VISC_W-1:0];
  assign heat_capacity_centi   = heat_val[wpi_pkg::HEAT_W-1:0];
  assign clamped               = clamped_dly[2];

endmodule

/* sv/wpi_seg.sv */
// ----------------------------------------------------------------------------
// wpi_seg : temperature to segment index and fraction
// Stage 1 converts to Celsius and classifies, stage 2 multiplies by the
// reciprocal of the knot step, stage 3 forms index and fraction.
// ----------------------------------------------------------------------------
module wpi_seg (
  input  logic                              clk,
  input  wpi_pkg::pipe_en_t                 en,
  input  logic [wpi_pkg::TK_W-1:0]          temperature_centikelvin,
  output logic [wpi_pkg::SEG_W-1:0]         seg_idx,
  output logic [wpi_pkg::FRAC_W-1:0]        frac,
  output logic                              clamped
);

  logic signed [wpi_pkg::TC_W-1:0] tc;
  logic                            tc_low;
  logic                            tc_high;

  // stage 1 registers
  logic [wpi_pkg::MID_W-1:0]  s1_mid;
  logic                       s1_low;
  logic                       s1_high;
  logic                       s1_clamped;

  // stage 2 registers
  logic [wpi_pkg::MID_W-1:0]  s2_mid;
  logic [wpi_pkg::SEGP_W-1:0] s2_prod;
  logic                       s2_low;
  logic                       s2_high;
  logic                       s2_clamped;

  // stage 3 combinational
  logic [wpi_pkg::SEG_W-1:0]  seg_raw;
  logic [wpi_pkg::SEG_W-1:0]  seg_mid;
  logic [wpi_pkg::MID_W-1:0]  seg_base;
  logic [wpi_pkg::MID_W-1:0]  frac_mid;
  logic [wpi_pkg::SEG_W-1:0]  seg_idx_next;
  logic [wpi_pkg::FRAC_W-1:0] frac_next;

  // Celsius and range class
  always_comb begin
    tc      = $signed({1'b0, temperature_centikelvin})
            - $signed(wpi_pkg::TC_W'(wpi_pkg::OFFSET_CK));
    tc_low  = tc[wpi_pkg::TC_W-1] || (tc == '0);
    tc_high = !tc[wpi_pkg::TC_W-1] && (tc >= $signed(wpi_pkg::TC_W'(wpi_pkg::TC_TOP)));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_low     <= tc_low;
      s1_high    <= tc_high;
      s1_clamped <= tc[wpi_pkg::TC_W-1] || (tc > $signed(wpi_pkg::TC_W'(wpi_pkg::TC_TOP)));
      s1_mid     <= (tc_low || tc_high) ? '0 : tc[wpi_pkg::MID_W-1:0];
    end
  end

  // reciprocal multiply for the segment number
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_prod    <= wpi_pkg::SEGP_W'(s1_mid) * wpi_pkg::SEGP_W'(wpi_pkg::SEG_RECIP);
      s2_mid     <= s1_mid;
      s2_low     <= s1_low;
      s2_high    <= s1_high;
      s2_clamped <= s1_clamped;
    end
  end

  // index and fraction; end classes pick the end knot with zero fraction
  always_comb begin
    seg_raw  = s2_prod[wpi_pkg::SEG_SHIFT +: wpi_pkg::SEG_W];
    seg_mid  = (32'(seg_raw) > wpi_pkg::KNOT_COUNT - 2)
             ? wpi_pkg::SEG_W'(wpi_pkg::KNOT_COUNT - 2) : seg_raw;
    seg_base = wpi_pkg::MID_W'(seg_mid) * wpi_pkg::MID_W'(wpi_pkg::KNOT_STEP);
    frac_mid = s2_mid - seg_base;
    if (s2_low) begin
      seg_idx_next = '0;
      frac_next    = '0;
    end else if (s2_high) begin
      seg_idx_next = wpi_pkg::SEG_W'(wpi_pkg::KNOT_COUNT - 1);
      frac_next    = '0;
    end else begin
      seg_idx_next = seg_mid;
      frac_next    = frac_mid[wpi_pkg::FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      seg_idx <= seg_idx_next;
      frac    <= frac_next;
      clamped <= s2_clamped;
    end
  end

endmodule

/* sv/wpi_lerp.sv */
// ----------------------------------------------------------------------------
// wpi_lerp : one interpolation lane
// Stage 4 reads the knot and slope and multiplies by the fraction, stage 5
// divides the biased rounded numerator by 1000, stage 6 adds the base knot.
// ----------------------------------------------------------------------------
module wpi_lerp (
  input  logic                        clk,
  input  wpi_pkg::pipe_en_t           en,
  input  logic [1:0]                  prop,
  input  logic [wpi_pkg::SEG_W-1:0]   seg_idx,
  input  logic [wpi_pkg::FRAC_W-1:0]  frac,
  output logic [wpi_pkg::VAL_W-1:0]   value
);

  logic [wpi_pkg::VAL_W-1:0]         s4_lo;
  logic signed [wpi_pkg::PROD_W-1:0] s4_prod;
  logic [wpi_pkg::VAL_W-1:0]         s5_lo;
  logic [wpi_pkg::QUO_W-1:0]         s5_quo;
  logic [wpi_pkg::NUM_W-1:0]         num;
  logic [wpi_pkg::DIVP_W-1:0]        div_prod;

  // base knot and fraction times slope
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_lo   <= wpi_pkg::knot_value(prop, seg_idx);
      s4_prod <= $signed({1'b0, frac}) * wpi_pkg::knot_delta(prop, seg_idx);
    end
  end

  // numerator kept positive by a bias of DIV_BIAS whole steps
  always_comb begin
    num      = wpi_pkg::NUM_W'(s4_prod)
             + wpi_pkg::NUM_W'(wpi_pkg::DIV_BIAS * wpi_pkg::KNOT_STEP + wpi_pkg::KNOT_STEP / 2);
    div_prod = wpi_pkg::DIVP_W'(num) * wpi_pkg::DIVP_W'(wpi_pkg::DIV_RECIP);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_lo  <= s4_lo;
      s5_quo <= div_prod[wpi_pkg::DIVP_W-1:wpi_pkg::DIV_SHIFT];
    end
  end

  // remove the bias and add the base knot
  always_ff @(posedge clk) begin
    if (en[5]) begin
      value <= s5_lo + wpi_pkg::VAL_W'(s5_quo) - wpi_pkg::VAL_W'(wpi_pkg::DIV_BIAS);
    end
  end

endmodule
